/* sv/lsfx_pkg.sv */
// Shared types, register codes and arithmetic constants of the LED strip effect generator.
package lsfx_pkg;

    // Strip geometry
    localparam int LED_COUNT = 64;
    localparam int IDX_W     = 6;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 3'd4;

    // Display mode codes
    localparam logic [1:0] MODE_SINGLE  = 2'd0;
    localparam logic [1:0] MODE_FLOW    = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;
    localparam logic [1:0] MODE_IDLE    = 2'd3;

    // Phase wrap points: chase window is 20 long, hue wheel is 6 sectors of 6 steps
    localparam logic [4:0] CHASE_LAST   = 5'd19;
    localparam logic [3:0] FADE_LEN     = 4'd15;
    localparam logic [2:0] HUE_SUB_LAST = 3'd5;
    localparam logic [2:0] HUE_SEC_LAST = 3'd5;

    // Reciprocals: x/24000 = ((x>>6)*RECIP_375)>>26, exact for x < SAT_LIMIT
    localparam logic [17:0] RECIP_375  = 18'd178957;
    localparam logic [22:0] SAT_LIMIT  = 23'd6144000;
    // x/100 = ((x>>2)*RECIP_25)>>18, exact for x < 2^13
    localparam logic [13:0] RECIP_25   = 14'd10486;
    // x/6 = ((x>>1)*RECIP_3)>>11, exact for x < 2^11
    localparam logic [9:0]  RECIP_3    = 10'd683;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    // Depth of the frame job queue
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef struct packed {
        logic action;
        logic settings_changed;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic             last_led;
    } t_out_req;

    typedef struct packed {
        logic [1:0]  display_mode;
        logic [7:0]  base_red;
        logic [7:0]  base_green;
        logic [7:0]  base_blue;
        logic [10:0] brightness_level;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_FLOW,
        KIND_RAINBOW
    } t_kind;

    // One frame of work: effect kind and the phases it starts from
    typedef struct packed {
        t_kind      kind;
        logic [4:0] chase;
        logic [2:0] hue_sec;
        logic [2:0] hue_sub;
    } t_job;

endpackage

/* sv/lsfx_front.sv */
// Front end: configuration registers, frame request classification and effect phases.
module lsfx_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsfx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsfx_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lsfx_pkg::t_in_req               i_in_req,
    input  logic                            i_q_full,
    output logic                            o_push,
    output lsfx_pkg::t_job                  o_job,
    output lsfx_pkg::t_cfg                  o_cfg
);

    localparam logic [1:0] MODE_RESET = lsfx_pkg::MODE_RAINBOW;

    lsfx_pkg::t_cfg r_cfg;
    logic           r_first, n_first;
    logic [4:0]     r_chase, n_chase;
    logic [2:0]     r_sec, n_sec;
    logic [2:0]     r_sub, n_sub;
    logic           w_tick;
    logic           w_changed;

    assign o_in_ready = !i_q_full;
    assign o_cfg      = r_cfg;
    assign w_tick     = i_in_valid && !i_q_full && (i_in_req.action == 1'b0);
    assign w_changed  = i_in_req.settings_changed || r_first;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_mode     <= MODE_RESET;
            r_cfg.base_red         <= '0;
            r_cfg.base_green       <= '0;
            r_cfg.base_blue        <= '0;
            r_cfg.brightness_level <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsfx_pkg::CFG_MODE:  r_cfg.display_mode     <= i_cfg_data[1:0];
                lsfx_pkg::CFG_RED:   r_cfg.base_red         <= i_cfg_data[7:0];
                lsfx_pkg::CFG_GREEN: r_cfg.base_green       <= i_cfg_data[7:0];
                lsfx_pkg::CFG_BLUE:  r_cfg.base_blue        <= i_cfg_data[7:0];
                lsfx_pkg::CFG_LEVEL: r_cfg.brightness_level <= i_cfg_data;
                default:             r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Classify the frame request and step the phase of the running effect
    always_comb begin
        o_push        = 1'b0;
        o_job.kind    = lsfx_pkg::KIND_SINGLE;
        o_job.chase   = r_chase;
        o_job.hue_sec = r_sec;
        o_job.hue_sub = r_sub;
        n_first       = r_first;
        n_chase       = r_chase;
        n_sec         = r_sec;
        n_sub         = r_sub;
        if (w_tick) begin
            n_first = 1'b0;
            case (r_cfg.display_mode)
                lsfx_pkg::MODE_SINGLE: begin
                    o_push     = w_changed;
                    o_job.kind = lsfx_pkg::KIND_SINGLE;
                end
                lsfx_pkg::MODE_FLOW: begin
                    o_push     = 1'b1;
                    o_job.kind = lsfx_pkg::KIND_FLOW;
                    n_chase    = (r_chase == lsfx_pkg::CHASE_LAST) ? '0 : r_chase + 5'd1;
                end
                lsfx_pkg::MODE_RAINBOW: begin
                    o_push     = 1'b1;
                    o_job.kind = lsfx_pkg::KIND_RAINBOW;
                    if (r_sub == lsfx_pkg::HUE_SUB_LAST) begin
                        n_sub = '0;
                        n_sec = (r_sec == lsfx_pkg::HUE_SEC_LAST) ? '0 : r_sec + 3'd1;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
                default: o_push = 1'b0;
            endcase
        end
    end

    // Phase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_chase <= '0;
            r_sec   <= '0;
            r_sub   <= '0;
        end else begin
            r_first <= n_first;
            r_chase <= n_chase;
            r_sec   <= n_sec;
            r_sub   <= n_sub;
        end
    end

endmodule

/* sv/lsfx_queue.sv */
// Small FIFO of frame jobs between the front end and the pixel engine.
module lsfx_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsfx_pkg::t_job i_job,
    input  logic           i_pop,
    output lsfx_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    lsfx_pkg::t_job                   r_mem [lsfx_pkg::QUEUE_DEPTH];
    logic [lsfx_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [lsfx_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [lsfx_pkg::QUEUE_AW:0]      r_count;

    assign o_full  = (r_count == (lsfx_pkg::QUEUE_AW + 1)'(lsfx_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/lsfx_engine.sv */
// Pixel engine: walks the strip for one frame job and computes each LED colour in a pipeline.
module lsfx_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsfx_pkg::t_cfg      i_cfg,
    input  logic                i_empty,
    input  lsfx_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsfx_pkg::t_out_req  o_out_req
);

    typedef struct packed {
        logic [lsfx_pkg::IDX_W-1:0] idx;
        logic                       last;
        logic                       rainbow;
        logic [2:0]                 sec;
        logic [2:0]                 sub;
    } t_meta;

    // Sequencer state
    logic                        r_busy;
    lsfx_pkg::t_kind             r_kind;
    logic [lsfx_pkg::IDX_W-1:0]  r_idx;
    logic [4:0]                  r_chase;
    logic [2:0]                  r_sec;
    logic [2:0]                  r_sub;

    logic                        w_adv;
    logic                        w_issue;
    logic                        w_last;
    logic [3:0]                  w_k;
    logic [2:0][7:0]             w_base;

    // Stage registers
    logic                        r1_valid, r2_valid, r3_valid, r_out_valid;
    t_meta                       r1_meta, r2_meta, r3_meta;
    logic [2:0][18:0]            r1_prod;
    logic [14:0]                 r1_u;
    logic [3:0]                  r1_k;
    logic [2:0][22:0]            r2_num;
    logic [8:0]                  r2_top_raw;
    logic [2:0][7:0]             r3_col;
    logic [7:0]                  r3_top;
    logic [10:0]                 r3_tm;
    lsfx_pkg::t_out_req          r_out;

    logic [27:0]                 w_top_prod;
    logic [7:0]                  w_top_sat;
    logic [2:0][34:0]            w_q_prod;
    logic [2:0][7:0]             w_col;
    logic [19:0]                 w_adj_prod;
    logic [7:0]                  w_adj;
    logic [7:0]                  w_dn;
    logic [7:0]                  w_r, w_g, w_b;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_pop       = !r_busy && !i_empty;
    assign w_issue     = r_busy && w_adv;
    assign w_last      = (r_idx == lsfx_pkg::IDX_W'(lsfx_pkg::LED_COUNT - 1));
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign w_base[0]   = i_cfg.base_red;
    assign w_base[1]   = i_cfg.base_green;
    assign w_base[2]   = i_cfg.base_blue;

    // Fade weight: full for single colour, tapering window for the chase
    always_comb begin
        case (r_kind)
            lsfx_pkg::KIND_SINGLE:
                w_k = lsfx_pkg::FADE_LEN;
            lsfx_pkg::KIND_FLOW:
                w_k = (r_chase < 5'(lsfx_pkg::FADE_LEN)) ?
                      lsfx_pkg::FADE_LEN - r_chase[3:0] : 4'd0;
            default:
                w_k = 4'd0;
        endcase
    end

    // LED sequencer: one LED issued per advancing cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_kind  <= lsfx_pkg::KIND_SINGLE;
            r_idx   <= '0;
            r_chase <= '0;
            r_sec   <= '0;
            r_sub   <= '0;
        end else if (o_pop) begin
            r_busy  <= 1'b1;
            r_kind  <= i_job.kind;
            r_idx   <= '0;
            r_chase <= i_job.chase;
            r_sec   <= i_job.hue_sec;
            r_sub   <= i_job.hue_sub;
        end else if (w_issue) begin
            r_idx   <= r_idx + 1'b1;
            r_chase <= (r_chase == lsfx_pkg::CHASE_LAST) ? '0 : r_chase + 5'd1;
            if (r_sub == lsfx_pkg::HUE_SUB_LAST) begin
                r_sub <= '0;
                r_sec <= (r_sec == lsfx_pkg::HUE_SEC_LAST) ? '0 : r_sec + 3'd1;
            end else begin
                r_sub <= r_sub + 3'd1;
            end
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Pipeline valid bits, all stages stall together on output back-pressure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= r_busy;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    // Stage 1: colour times brightness, percent times full scale
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r1_prod[c] <= 19'(w_base[c]) * 19'(i_cfg.brightness_level);
            end
            r1_u            <= 15'(i_cfg.brightness_level[10:4]) * 15'(lsfx_pkg::FULL_SCALE);
            r1_k            <= w_k;
            r1_meta.idx     <= r_idx;
            r1_meta.last    <= w_last;
            r1_meta.rainbow <= (r_kind == lsfx_pkg::KIND_RAINBOW);
            r1_meta.sec     <= r_sec;
            r1_meta.sub     <= r_sub;
        end
    end

    // Stage 2: apply fade weight; rainbow peak = u / 100
    assign w_top_prod = 28'(r1_u[14:2]) * 28'(lsfx_pkg::RECIP_25);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r2_num[c] <= 23'(r1_prod[c]) * 23'(r1_k);
            end
            r2_top_raw <= w_top_prod[26:18];
            r2_meta    <= r1_meta;
        end
    end

    // Stage 3: divide by 24000 with saturation; peak saturation and peak times sub-step
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_q_prod[c] = 35'(r2_num[c][22:6]) * 35'(lsfx_pkg::RECIP_375);
            w_col[c]    = (r2_num[c] >= lsfx_pkg::SAT_LIMIT) ?
                          lsfx_pkg::FULL_SCALE : w_q_prod[c][33:26];
        end
        w_top_sat = (r2_top_raw > 9'(lsfx_pkg::FULL_SCALE)) ?
                    lsfx_pkg::FULL_SCALE : r2_top_raw[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_col  <= w_col;
            r3_top  <= w_top_sat;
            r3_tm   <= 11'(w_top_sat) * 11'(r2_meta.sub);
            r3_meta <= r2_meta;
        end
    end

    // Output stage: hue ramp value, sector select
    assign w_adj_prod = 20'(r3_tm[10:1]) * 20'(lsfx_pkg::RECIP_3);
    assign w_adj      = w_adj_prod[18:11];
    assign w_dn       = r3_top - w_adj;

    always_comb begin
        if (r3_meta.rainbow) begin
            case (r3_meta.sec)
                3'd0: begin w_r = r3_top; w_g = w_adj;  w_b = '0;     end
                3'd1: begin w_r = w_dn;   w_g = r3_top; w_b = '0;     end
                3'd2: begin w_r = '0;     w_g = r3_top; w_b = w_adj;  end
                3'd3: begin w_r = '0;     w_g = w_dn;   w_b = r3_top; end
                3'd4: begin w_r = w_adj;  w_g = '0;     w_b = r3_top; end
                default: begin w_r = r3_top; w_g = '0;  w_b = w_dn;   end
            endcase
        end else begin
            w_r = r3_col[0];
            w_g = r3_col[1];
            w_b = r3_col[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.led_index <= r3_meta.idx;
            r_out.out_red   <= w_r;
            r_out.out_green <= w_g;
            r_out.out_blue  <= w_b;
            r_out.last_led  <= r3_meta.last;
        end
    end

endmodule

/* sv/led_strip_effect_generator.sv */
// The first colour of a frame goes through the job queue, sequencer and pipeline registers.
// Throughput: one colour per cycle within a frame while the output is taken; each frame of
// 64 LEDs costs one job load, then the sequencer issues one LED per cycle.
// The front end keeps taking requests while the 2-entry job queue has room.
// Reset: synchronous active-low i_rst_n; mode returns to rainbow, colour and brightness to 0,
// phases to 0, and the first frame after reset counts as changed.
module led_strip_effect_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsfx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsfx_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lsfx_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lsfx_pkg::t_out_req              o_out_req
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    lsfx_pkg::t_job w_job_in;
    lsfx_pkg::t_job w_job_out;
    lsfx_pkg::t_cfg w_cfg;

    // Request classification and configuration
    lsfx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in),
        .o_cfg      (w_cfg)
    );

    // Frame job queue
    lsfx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Per-LED colour pipeline
    lsfx_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_empty     (w_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

`ifndef NO_ASSERTIONS
    // The last-LED flag only ever marks the final strip position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.last_led) |->
        (o_out_req.led_index == lsfx_pkg::IDX_W'(lsfx_pkg::LED_COUNT - 1)))
        else $error("last_led set on a position other than the final LED");

    // Front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("frame job pushed into a full queue");

    // Engine never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("frame job popped from an empty queue");
`endif

endmodule

/* tb/led_strip_effect_generator_test.sv */
// Self-checking testbench for the LED strip effect generator: frame ticks in, per-LED colours out.
module led_strip_effect_generator_test;

    localparam int RANDOM_FRAMES = 120;
    localparam int SETTLE_CYCLES = 3 * (lsfx_pkg::LED_COUNT + 8);
    localparam int MAX_REPORTS   = 10;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lsfx_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [lsfx_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    lsfx_pkg::t_in_req              i_in_req;
    logic                           o_out_valid;
    logic                           i_out_ready;
    lsfx_pkg::t_out_req             o_out_req;

    // Frame requests waiting for the driver, and colours the strip still owes us
    lsfx_pkg::t_in_req  pending_frames[$];
    lsfx_pkg::t_out_req expected_colors[$];

    // Shadow of the register file and the effect phases
    int unsigned mode_q, red_q, green_q, blue_q, level_q;
    int unsigned chase_q, hue_q;
    bit          first_tick;

    bit frame_taken;
    bit steady;
    int mismatches;
    int ticks_sent, noise_sent, colours_checked, reg_writes;

    led_strip_effect_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clip8(input int unsigned v);
        return (v > lsfx_pkg::FULL_SCALE) ? lsfx_pkg::FULL_SCALE : v[7:0];
    endfunction

    // Colours of one frame tick, appended in LED order
    task automatic paint_frame(input lsfx_pkg::t_in_req req);
        lsfx_pkg::t_out_req c;
        bit                 changed;
        int unsigned        i, t, k, h, adj, top, r, g, b;
        if (req.action) return;
        changed    = req.settings_changed || first_tick;
        first_tick = 1'b0;
        if (mode_q == lsfx_pkg::MODE_IDLE
            || (mode_q == lsfx_pkg::MODE_SINGLE && !changed)) return;
        top = clip8(level_q / 16 * 255 / 100);
        for (i = 0; i < lsfx_pkg::LED_COUNT; i++) begin
            case (mode_q)
                lsfx_pkg::MODE_SINGLE: begin
                    r = red_q * level_q / 1600;
                    g = green_q * level_q / 1600;
                    b = blue_q * level_q / 1600;
                end
                lsfx_pkg::MODE_FLOW: begin
                    t = (i + chase_q) % 20;
                    k = (t < lsfx_pkg::FADE_LEN) ? lsfx_pkg::FADE_LEN - t : 0;
                    r = red_q * level_q * k / 24000;
                    g = green_q * level_q * k / 24000;
                    b = blue_q * level_q * k / 24000;
                end
                default: begin
                    h   = ((i + hue_q) % 36) * 10;
                    adj = top * (h % 60) / 60;
                    case (h / 60)
                        0:       begin r = top;       g = adj;       b = 0;         end
                        1:       begin r = top - adj; g = top;       b = 0;         end
                        2:       begin r = 0;         g = top;       b = adj;       end
                        3:       begin r = 0;         g = top - adj; b = top;       end
                        4:       begin r = adj;       g = 0;         b = top;       end
                        default: begin r = top;       g = 0;         b = top - adj; end
                    endcase
                end
            endcase
            c.led_index = i[lsfx_pkg::IDX_W-1:0];
            c.out_red   = clip8(r);
            c.out_green = clip8(g);
            c.out_blue  = clip8(b);
            c.last_led  = (i == lsfx_pkg::LED_COUNT - 1);
            expected_colors.push_back(c);
        end
        // phases move only on frames of their own effect
        if (mode_q == lsfx_pkg::MODE_FLOW)
            chase_q = (chase_q == lsfx_pkg::CHASE_LAST) ? 0 : chase_q + 1;
        if (mode_q == lsfx_pkg::MODE_RAINBOW) hue_q = (hue_q == 35) ? 0 : hue_q + 1;
    endtask

    // Request driver: new request only once the previous one is gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || frame_taken) begin
            if (pending_frames.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
                i_in_valid <= 1'b1;
                i_in_req   <= pending_frames.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        frame_taken = 1'b0;
    end

    // Colour sink stalls at random, except in the steady phases
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 16);
    end

    // Monitor: predict on accepted requests, check accepted colours
    always @(posedge i_clk) begin
        lsfx_pkg::t_out_req want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                paint_frame(i_in_req);
                frame_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                colours_checked++;
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected colour: idx %0d rgb %0d/%0d/%0d last %0b",
                                 o_out_req.led_index, o_out_req.out_red,
                                 o_out_req.out_green, o_out_req.out_blue, o_out_req.last_led);
                end else begin
                    want = expected_colors.pop_front();
                    if (o_out_req.led_index !== want.led_index
                        || o_out_req.out_red !== want.out_red
                        || o_out_req.out_green !== want.out_green
                        || o_out_req.out_blue !== want.out_blue
                        || o_out_req.last_led !== want.last_led) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("colour mismatch: exp idx %0d rgb %0d/%0d/%0d last %0b, %s",
                                     want.led_index, want.out_red, want.out_green,
                                     want.out_blue, want.last_led,
                                     $sformatf("got idx %0d rgb %0d/%0d/%0d last %0b",
                                               o_out_req.led_index, o_out_req.out_red,
                                               o_out_req.out_green, o_out_req.out_blue,
                                               o_out_req.last_led));
                    end
                end
            end
        end
    end

    // Register write; only called while the strip is idle
    task automatic set_reg(input logic [lsfx_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[lsfx_pkg::CFG_W-1:0];
        case (idx)
            lsfx_pkg::CFG_MODE:  mode_q  = value & 3;
            lsfx_pkg::CFG_RED:   red_q   = value & 255;
            lsfx_pkg::CFG_GREEN: green_q = value & 255;
            lsfx_pkg::CFG_BLUE:  blue_q  = value & 255;
            lsfx_pkg::CFG_LEVEL: level_q = value & 2047;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_frame(input bit action, input bit changed);
        lsfx_pkg::t_in_req req;
        req.action           = action;
        req.settings_changed = changed;
        pending_frames.push_back(req);
        if (action) noise_sent++;
        else ticks_sent++;
    endtask

    // Sender holds off until every request is taken and every colour is back
    task automatic wait_drained();
        while (pending_frames.size() != 0 || i_in_valid || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_level();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1600;
            2:       return 2047;
            3:       return $urandom_range(2047, 1601);
            default: return $urandom_range(1600, 0);
        endcase
    endfunction

    function automatic int unsigned pick_colour();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic int unsigned pick_mode();
        int unsigned m;
        m = $urandom_range(9);
        if (m < 2) return lsfx_pkg::MODE_SINGLE;
        if (m < 5) return lsfx_pkg::MODE_FLOW;
        if (m < 9) return lsfx_pkg::MODE_RAINBOW;
        return lsfx_pkg::MODE_IDLE;
    endfunction

    // Stimulus
    initial begin
        int random_ticks;
        int phase;
        int burst;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_out_ready = 1'b0;
        mode_q      = lsfx_pkg::MODE_RAINBOW;
        red_q       = 0;
        green_q     = 0;
        blue_q      = 0;
        level_q     = 0;
        chase_q     = 0;
        hue_q       = 0;
        first_tick  = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single colour: first tick after reset paints even without the flag
        set_reg(lsfx_pkg::CFG_MODE, lsfx_pkg::MODE_SINGLE);
        set_reg(lsfx_pkg::CFG_RED, 255);
        set_reg(lsfx_pkg::CFG_GREEN, 128);
        set_reg(lsfx_pkg::CFG_BLUE, 1);
        set_reg(lsfx_pkg::CFG_LEVEL, 1600);
        queue_frame(0, 0);
        queue_frame(0, 0);
        queue_frame(0, 1);
        queue_frame(1, 1);
        queue_frame(1, 0);
        wait_drained();
        // brightness beyond full saturates, zero gives black
        set_reg(lsfx_pkg::CFG_LEVEL, 2047);
        queue_frame(0, 1);
        wait_drained();
        set_reg(lsfx_pkg::CFG_LEVEL, 0);
        queue_frame(0, 1);
        wait_drained();

        // flowing chase
        set_reg(lsfx_pkg::CFG_MODE, lsfx_pkg::MODE_FLOW);
        set_reg(lsfx_pkg::CFG_RED, 200);
        set_reg(lsfx_pkg::CFG_GREEN, 0);
        set_reg(lsfx_pkg::CFG_BLUE, 255);
        set_reg(lsfx_pkg::CFG_LEVEL, 1600);
        queue_frame(0, 0);
        queue_frame(0, 1);
        queue_frame(1, 0);
        wait_drained();
        set_reg(lsfx_pkg::CFG_LEVEL, 2047);
        queue_frame(0, 0);
        wait_drained();

        // rainbow at full, saturated and zero value
        set_reg(lsfx_pkg::CFG_MODE, lsfx_pkg::MODE_RAINBOW);
        set_reg(lsfx_pkg::CFG_LEVEL, 1600);
        queue_frame(0, 0);
        queue_frame(0, 1);
        wait_drained();
        set_reg(lsfx_pkg::CFG_LEVEL, 2047);
        queue_frame(0, 0);
        wait_drained();
        set_reg(lsfx_pkg::CFG_LEVEL, 15);
        queue_frame(0, 0);
        wait_drained();

        // idle mode: silent, and both phases must hold
        set_reg(lsfx_pkg::CFG_MODE, lsfx_pkg::MODE_IDLE);
        queue_frame(0, 1);
        queue_frame(0, 0);
        wait_drained();
        set_reg(lsfx_pkg::CFG_MODE, lsfx_pkg::MODE_RAINBOW);
        set_reg(lsfx_pkg::CFG_LEVEL, 1000);
        queue_frame(0, 0);
        wait_drained();
        set_reg(lsfx_pkg::CFG_MODE, lsfx_pkg::MODE_FLOW);
        queue_frame(0, 0);
        wait_drained();

        // random settings, each followed by a burst of ticks mixed with ignored requests
        random_ticks = 0;
        phase        = 0;
        while (random_ticks < RANDOM_FRAMES) begin
            phase++;
            steady = (phase == 3 || phase == 4);
            set_reg(lsfx_pkg::CFG_MODE, pick_mode());
            if (phase == 1 || $urandom_range(9) < 7) set_reg(lsfx_pkg::CFG_RED, pick_colour());
            if (phase == 1 || $urandom_range(9) < 7) set_reg(lsfx_pkg::CFG_GREEN, pick_colour());
            if (phase == 1 || $urandom_range(9) < 7) set_reg(lsfx_pkg::CFG_BLUE, pick_colour());
            if (phase == 1 || $urandom_range(9) < 7) set_reg(lsfx_pkg::CFG_LEVEL, pick_level());
            burst = $urandom_range(24, 8);
            for (int j = 0; j < burst; j++) begin
                if ($urandom_range(9) == 0) begin
                    queue_frame(1, $urandom_range(1));
                end else begin
                    queue_frame(0, $urandom_range(1));
                    random_ticks++;
                end
            end
            wait_drained();
        end
        steady = 1'b0;

        $display("Sent %0d frame ticks and %0d ignored requests across %0d register writes;",
                 ticks_sent, noise_sent, reg_writes);
        $display("checked %0d colours over single, flow, rainbow and idle settings.",
                 colours_checked);
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
